### hw/rtl/gdb_rsp_packet_receiver_top_assert.svh
// Assertion macros shared by the packet receiver RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef GDB_RSP_PACKET_RECEIVER_TOP_ASSERT_SVH
`define GDB_RSP_PACKET_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication.
`define GDBRX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdbrx: same-cycle check failed");

// Next-cycle implication.
`define GDBRX_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdbrx: next-cycle check failed");

`endif

### hw/rtl/gdbrx_pkg.sv
// ----------------------------------------------------------------------------
// gdbrx_pkg
// Types, constants and helpers for the remote serial protocol packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package gdbrx_pkg;

    localparam int MAX_PACKET = 4096;
    localparam int COUNT_W    = 12;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_ESC   = 8'h7D;
    localparam logic [7:0] ESC_XOR  = 8'h20;

    localparam logic [COUNT_W-1:0] MAX_PAYLOAD_RESET = 12'hFFF;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_NAK     = 2'd2,
        KIND_DISCARD = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAYLOAD,
        ST_ESCAPE,
        ST_CK_HIGH,
        ST_CK_LOW
    } rx_state_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Decode one ASCII hex digit; ok is low for anything else.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gdb_rsp_packet_receiver_top.sv
// Each accepted byte is held in the input register; its result (if any) is registered in the result register.
// Throughput: one byte per cycle; the input register and the result register
// advance together, so input stalls only while a result waits on out_ready.
// Configuration writes are taken in any cycle (cfg_ready is held high).
// Reset: receiver idle, no result pending, max_payload back to 4095.
// ----------------------------------------------------------------------------
// gdb_rsp_packet_receiver_top
// Receive-side packet parser: framing, unescaping, checksum and ACK/NAK.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gdb_rsp_packet_receiver_top_assert.svh"

module gdb_rsp_packet_receiver_top #(
    parameter int MAX_PACKET = gdbrx_pkg::MAX_PACKET
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [gdbrx_pkg::COUNT_W-1:0] max_payload,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   rx_byte,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        kind,
    output logic [7:0]                        payload_byte,
    output logic [gdbrx_pkg::COUNT_W-1:0]      packet_length
);

    localparam int CW = gdbrx_pkg::COUNT_W;
    localparam int CountMax = (1 << CW) - 1;
    localparam logic [CW-1:0] HardLimit =
        CW'((MAX_PACKET - 1) > CountMax ? CountMax : (MAX_PACKET - 1));

    logic [CW-1:0]         max_payload_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    gdbrx_pkg::rx_state_t  state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [7:0]            sum_reg, sum_next;
    logic [3:0]            high_reg, high_next;
    logic                  out_valid_reg;
    gdbrx_pkg::kind_t      kind_reg, res_kind;
    logic [7:0]            byte_reg, res_byte;
    logic [CW-1:0]         len_reg, res_len;
    logic                  res_valid;

    logic                  advance;
    logic                  fire;
    logic [CW-1:0]         limit;
    logic                  over;
    logic [7:0]            data_byte;
    gdbrx_pkg::hex_t       hex;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || out_ready;
    assign in_ready      = !in_valid_reg || advance;
    assign fire          = in_valid_reg && advance;

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign payload_byte  = byte_reg;
    assign packet_length = len_reg;

    assign limit     = (max_payload_reg < HardLimit) ? max_payload_reg : HardLimit;
    assign over      = count_reg >= limit;
    assign data_byte = (state_reg == gdbrx_pkg::ST_ESCAPE)
                       ? (in_byte_reg ^ gdbrx_pkg::ESC_XOR) : in_byte_reg;
    assign hex       = gdbrx_pkg::hex_decode(in_byte_reg);

    // Next state and packet bookkeeping
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        high_next  = high_reg;
        unique case (state_reg)
            gdbrx_pkg::ST_IDLE:
            begin
                if (in_byte_reg == gdbrx_pkg::CH_START) begin
                    state_next = gdbrx_pkg::ST_PAYLOAD;
                end
            end
            gdbrx_pkg::ST_PAYLOAD,
            gdbrx_pkg::ST_ESCAPE:
            begin
                if (state_reg == gdbrx_pkg::ST_PAYLOAD
                    && in_byte_reg == gdbrx_pkg::CH_ESC) begin
                    sum_next   = sum_reg + in_byte_reg;
                    state_next = gdbrx_pkg::ST_ESCAPE;
                end
                else if (state_reg == gdbrx_pkg::ST_PAYLOAD
                         && in_byte_reg == gdbrx_pkg::CH_END) begin
                    state_next = gdbrx_pkg::ST_CK_HIGH;
                end
                else if (over) begin
                    state_next = gdbrx_pkg::ST_IDLE;
                end
                else begin
                    sum_next   = sum_reg + in_byte_reg;
                    count_next = count_reg + CW'(1);
                    state_next = gdbrx_pkg::ST_PAYLOAD;
                end
            end
            gdbrx_pkg::ST_CK_HIGH:
            begin
                high_next  = hex.val;
                state_next = hex.ok ? gdbrx_pkg::ST_CK_LOW : gdbrx_pkg::ST_IDLE;
            end
            gdbrx_pkg::ST_CK_LOW:
            begin
                state_next = gdbrx_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gdbrx_pkg::ST_IDLE;
            end
        endcase
        // Leaving the packet clears the bookkeeping
        if (state_next == gdbrx_pkg::ST_IDLE) begin
            count_next = '0;
            sum_next   = '0;
            high_next  = '0;
        end
    end

    // Result for the byte in the input register
    always_comb
    begin
        res_valid = 1'b0;
        res_kind  = gdbrx_pkg::KIND_PAYLOAD;
        res_byte  = 8'd0;
        res_len   = count_reg;
        unique case (state_reg)
            gdbrx_pkg::ST_IDLE:
            begin
                res_valid = 1'b0;
            end
            gdbrx_pkg::ST_PAYLOAD,
            gdbrx_pkg::ST_ESCAPE:
            begin
                if (state_reg == gdbrx_pkg::ST_PAYLOAD
                    && (in_byte_reg == gdbrx_pkg::CH_ESC
                        || in_byte_reg == gdbrx_pkg::CH_END)) begin
                    res_valid = 1'b0;
                end
                else if (over) begin
                    res_valid = 1'b1;
                    res_kind  = gdbrx_pkg::KIND_DISCARD;
                end
                else begin
                    res_valid = 1'b1;
                    res_byte  = data_byte;
                    res_len   = count_reg + CW'(1);
                end
            end
            gdbrx_pkg::ST_CK_HIGH:
            begin
                if (!hex.ok) begin
                    res_valid = 1'b1;
                    res_kind  = gdbrx_pkg::KIND_DISCARD;
                end
            end
            gdbrx_pkg::ST_CK_LOW:
            begin
                res_valid = 1'b1;
                if (!hex.ok) begin
                    res_kind = gdbrx_pkg::KIND_DISCARD;
                end
                else if ({high_reg, hex.val} == sum_reg) begin
                    res_kind = gdbrx_pkg::KIND_ACK;
                end
                else begin
                    res_kind = gdbrx_pkg::KIND_NAK;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_payload_reg <= gdbrx_pkg::MAX_PAYLOAD_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= gdbrx_pkg::ST_IDLE;
            count_reg       <= '0;
            sum_reg         <= '0;
            high_reg        <= '0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                max_payload_reg <= max_payload;
            end
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= fire && res_valid;
            end
            if (fire) begin
                state_reg <= state_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
                high_reg  <= high_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_byte_reg <= rx_byte;
        end
        if (fire && res_valid) begin
            kind_reg <= res_kind;
            byte_reg <= res_byte;
            len_reg  <= res_len;
        end
    end

    `GDBRX_ASSERT_NXT(a_end_goes_idle,
        fire && res_valid && res_kind != gdbrx_pkg::KIND_PAYLOAD,
        state_reg == gdbrx_pkg::ST_IDLE)
    `GDBRX_ASSERT_IMP(a_idle_count_clear,
        state_reg == gdbrx_pkg::ST_IDLE, count_reg == '0 && sum_reg == '0)
    `GDBRX_ASSERT_IMP(a_byte_zero_on_status,
        out_valid_reg && kind_reg != gdbrx_pkg::KIND_PAYLOAD, byte_reg == 8'd0)
    `GDBRX_ASSERT_IMP(a_count_within_limit,
        state_reg != gdbrx_pkg::ST_IDLE, count_reg <= HardLimit)

endmodule

`default_nettype wire
